// File: hdl/lbcc_pkg.sv
package lbcc_pkg;

  localparam int unsigned CORDIC_STEPS_DFLT = 16;
  localparam int unsigned ATAN_IDX_W = 5;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X_LOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_LOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_HIGH = 3'd5;

  localparam logic signed [31:0] START_ANGLE_RST = -32'sd843314857;
  localparam logic signed [31:0] ANGLE_STEP_RST = 32'sd1561694;
  localparam logic signed [15:0] BOX_X_LOW_RST = -16'sd1311;
  localparam logic signed [15:0] BOX_X_HIGH_RST = 16'sd328;
  localparam logic signed [15:0] BOX_Y_LOW_RST = -16'sd819;
  localparam logic signed [15:0] BOX_Y_HIGH_RST = 16'sd819;

  localparam logic signed [31:0] PI_Q28 = 32'sd843314857;
  localparam logic signed [31:0] TWO_PI_Q28 = 32'sd1686629713;
  localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

  // queue depth, power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [31:0] start_angle;
    logic signed [31:0] angle_step;
    logic signed [15:0] box_x_low;
    logic signed [15:0] box_x_high;
    logic signed [15:0] box_y_low;
    logic signed [15:0] box_y_high;
  } cfg_t;

  typedef struct packed {
    logic               load;
    logic signed [31:0] angle;
  } start_ld_t;

  typedef struct packed {
    logic signed [31:0] angle;
    logic               neg;
    logic [15:0]        range;
    logic               last_beam;
  } beam_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ROT,
    B_MULX,
    B_MULY,
    B_CHECK
  } back_state_e;

  function automatic logic signed [31:0] atan_q28(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0: v = 32'sd210828714;
      5'd1: v = 32'sd124459457;
      5'd2: v = 32'sd65760959;
      5'd3: v = 32'sd33381290;
      5'd4: v = 32'sd16755422;
      5'd5: v = 32'sd8385879;
      5'd6: v = 32'sd4193963;
      5'd7: v = 32'sd2097109;
      5'd8: v = 32'sd1048571;
      5'd9: v = 32'sd524287;
      5'd10: v = 32'sd262144;
      5'd11: v = 32'sd131072;
      5'd12: v = 32'sd65536;
      5'd13: v = 32'sd32768;
      5'd14: v = 32'sd16384;
      5'd15: v = 32'sd8192;
      5'd16: v = 32'sd4096;
      5'd17: v = 32'sd2048;
      5'd18: v = 32'sd1024;
      5'd19: v = 32'sd512;
      5'd20: v = 32'sd256;
      5'd21: v = 32'sd128;
      5'd22: v = 32'sd64;
      5'd23: v = 32'sd32;
      5'd24: v = 32'sd16;
      5'd25: v = 32'sd8;
      5'd26: v = 32'sd4;
      5'd27: v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/lbcc_in_if.sv
interface lbcc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range;
  logic        last_beam;

  modport source (output valid, output range, output last_beam, input ready);
  modport sink (input valid, input range, input last_beam, output ready);
endinterface

// File: hdl/lbcc_out_if.sv
interface lbcc_out_if;
  logic valid;
  logic ready;
  logic collision;

  modport source (output valid, output collision, input ready);
  modport sink (input valid, input collision, output ready);
endinterface

// File: hdl/lbcc_front.sv
module lbcc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lbcc_in_if.sink              in_i,
  input  lbcc_pkg::cfg_t       cfg_i,
  input  lbcc_pkg::start_ld_t  start_ld_i,
  input  logic                 full_i,
  output logic                 push_o,
  output lbcc_pkg::beam_t      beam_o
);
  import lbcc_pkg::*;

  logic signed [31:0] beam_angle_q, beam_angle_d;
  logic signed [31:0] a_red;
  logic signed [31:0] a_fold;
  logic               neg;
  logic               accept;

  assign in_i.ready = !full_i;
  assign accept = in_i.valid && !full_i;

  // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    if (beam_angle_q > PI_Q28) begin
      a_red = beam_angle_q - TWO_PI_Q28;
    end else if (beam_angle_q < -PI_Q28) begin
      a_red = beam_angle_q + TWO_PI_Q28;
    end else begin
      a_red = beam_angle_q;
    end
    if (a_red > HALF_PI_Q28) begin
      a_fold = a_red - PI_Q28;
      neg = 1'b1;
    end else if (a_red < -HALF_PI_Q28) begin
      a_fold = a_red + PI_Q28;
      neg = 1'b1;
    end else begin
      a_fold = a_red;
      neg = 1'b0;
    end
  end

  always_comb begin
    beam_angle_d = beam_angle_q;
    if (start_ld_i.load) begin
      beam_angle_d = start_ld_i.angle;
    end else if (accept) begin
      if (in_i.last_beam) begin
        beam_angle_d = cfg_i.start_angle;
      end else begin
        beam_angle_d = beam_angle_q + cfg_i.angle_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_angle_q <= START_ANGLE_RST;
    end else begin
      beam_angle_q <= beam_angle_d;
    end
  end

  assign push_o = accept;
  assign beam_o.angle = a_fold;
  assign beam_o.neg = neg;
  assign beam_o.range = in_i.range;
  assign beam_o.last_beam = in_i.last_beam;

endmodule

// File: hdl/lbcc_fifo.sv
module lbcc_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lbcc_pkg::beam_t  data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output lbcc_pkg::beam_t  data_o
);
  import lbcc_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  beam_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign full_o = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && valid_o;
  assign data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
`endif

endmodule

// File: hdl/lbcc_back.sv
module lbcc_back #(
  parameter int unsigned CORDIC_STEPS = lbcc_pkg::CORDIC_STEPS_DFLT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lbcc_pkg::cfg_t   cfg_i,
  input  logic             valid_i,
  input  lbcc_pkg::beam_t  beam_i,
  output logic             pop_o,
  lbcc_out_if.source       out_o
);
  import lbcc_pkg::*;

  localparam int unsigned CNT_W = $clog2(CORDIC_STEPS);

  back_state_e        state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               hit_q, hit_d;
  logic               out_valid_q, out_valid_d;
  logic               out_coll_q;
  logic               out_ld;

  logic signed [31:0] x_q, x_d, y_q, y_d, a_q, a_d;
  logic               neg_q, neg_d;
  logic [15:0]        range_q, range_d;
  logic               last_q, last_d;
  logic signed [48:0] px_q, px_d, py_q, py_d;

  logic signed [31:0] x_sh, y_sh, atan_v;
  logic signed [31:0] cos_s, sin_s, mul_b;
  logic signed [16:0] mul_a;
  logic signed [48:0] prod;
  logic signed [48:0] xl_ext, xh_ext, yl_ext, yh_ext;
  logic               in_box;

  assign x_sh = x_q >>> cnt_q;
  assign y_sh = y_q >>> cnt_q;
  assign atan_v = atan_q28(ATAN_IDX_W'(cnt_q));

  assign cos_s = neg_q ? -x_q : x_q;
  assign sin_s = neg_q ? -y_q : y_q;
  assign mul_a = $signed({1'b0, range_q});
  assign mul_b = (state_q == B_MULY) ? sin_s : cos_s;
  assign prod = mul_a * mul_b;

  assign xl_ext = $signed({{3{cfg_i.box_x_low[15]}}, cfg_i.box_x_low, 30'd0});
  assign xh_ext = $signed({{3{cfg_i.box_x_high[15]}}, cfg_i.box_x_high, 30'd0});
  assign yl_ext = $signed({{3{cfg_i.box_y_low[15]}}, cfg_i.box_y_low, 30'd0});
  assign yh_ext = $signed({{3{cfg_i.box_y_high[15]}}, cfg_i.box_y_high, 30'd0});
  assign in_box = (px_q > xl_ext) && (px_q < xh_ext) && (py_q > yl_ext) && (py_q < yh_ext);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    hit_d = hit_q;
    x_d = x_q;
    y_d = y_q;
    a_d = a_q;
    neg_d = neg_q;
    range_d = range_q;
    last_d = last_q;
    px_d = px_q;
    py_d = py_q;
    pop_o = 1'b0;
    out_ld = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          x_d = GAIN_Q30;
          y_d = '0;
          a_d = beam_i.angle;
          neg_d = beam_i.neg;
          range_d = beam_i.range;
          last_d = beam_i.last_beam;
          cnt_d = '0;
          state_d = B_ROT;
        end
      end
      B_ROT: begin
        if (!a_q[31]) begin
          x_d = x_q - y_sh;
          y_d = y_q + x_sh;
          a_d = a_q - atan_v;
        end else begin
          x_d = x_q + y_sh;
          y_d = y_q - x_sh;
          a_d = a_q + atan_v;
        end
        if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
          cnt_d = '0;
          state_d = B_MULX;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      B_MULX: begin
        px_d = prod;
        state_d = B_MULY;
      end
      B_MULY: begin
        py_d = prod;
        state_d = B_CHECK;
      end
      B_CHECK: begin
        if (last_q) begin
          if (!out_valid_q || out_o.ready) begin
            out_ld = 1'b1;
            hit_d = 1'b0;
            state_d = B_IDLE;
          end
        end else begin
          hit_d = hit_q | in_box;
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q <= '0;
      hit_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      hit_q <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    a_q <= a_d;
    neg_q <= neg_d;
    range_q <= range_d;
    last_q <= last_d;
    px_q <= px_d;
    py_q <= py_d;
    if (out_ld) begin
      out_coll_q <= hit_q | in_box;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.collision = out_coll_q;

`ifndef SYNTHESIS
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != B_ROT |-> cnt_q == '0) else $error("step counter not cleared");
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ld |=> out_valid_q && !hit_q && state_q == B_IDLE) else $error("scan end not cleared");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == B_CHECK && last_q)) else $error("result without last beam");
`endif

endmodule

// File: hdl/lidar_box_collision_check.sv
// lidar point-in-box check over one scan
// in_i carries one range reading per beam with a last_beam mark; a transfer
// happens when valid and ready are both high. out_o carries one collision
// bit per scan, sent only for the beam marked last.
// the front end tracks the beam angle, wraps it into the cordic range and
// pushes the beam into a two-entry queue; the back end runs the rotation,
// two multiplies through one shared multiplier and the box compare.
// the back end pops a beam, then runs CORDIC_STEPS rotation steps, two
// multiplies and one compare on it; it takes no new beam from the queue
// until it is through with the last one. while the receiver stalls, the
// result is held in the output register, the back end stops at the next
// last beam and the queue fills, then in_i.ready drops.
// reset clears the queue, the scan flag and the output, and restores the
// configuration registers to their defaults. a write of start_angle
// restarts the angle sequence.
module lidar_box_collision_check #(
  parameter int unsigned CORDIC_STEPS = lbcc_pkg::CORDIC_STEPS_DFLT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lbcc_in_if.sink                          in_i,
  lbcc_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [lbcc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lbcc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import lbcc_pkg::*;

  cfg_t       cfg_q, cfg_d;
  start_ld_t  start_ld;
  logic       push, full, pop, q_valid;
  beam_t      push_beam, pop_beam;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_ANGLE: cfg_d.start_angle = $signed(cfg_data_i);
        REG_ANGLE_STEP: cfg_d.angle_step = $signed(cfg_data_i);
        REG_BOX_X_LOW: cfg_d.box_x_low = $signed(cfg_data_i[15:0]);
        REG_BOX_X_HIGH: cfg_d.box_x_high = $signed(cfg_data_i[15:0]);
        REG_BOX_Y_LOW: cfg_d.box_y_low = $signed(cfg_data_i[15:0]);
        REG_BOX_Y_HIGH: cfg_d.box_y_high = $signed(cfg_data_i[15:0]);
        default: begin
        end
      endcase
    end
  end

  assign start_ld.load = cfg_we_i && (cfg_idx_i == REG_START_ANGLE);
  assign start_ld.angle = $signed(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_angle <= START_ANGLE_RST;
      cfg_q.angle_step <= ANGLE_STEP_RST;
      cfg_q.box_x_low <= BOX_X_LOW_RST;
      cfg_q.box_x_high <= BOX_X_HIGH_RST;
      cfg_q.box_y_low <= BOX_Y_LOW_RST;
      cfg_q.box_y_high <= BOX_Y_HIGH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lbcc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg_q),
    .start_ld_i (start_ld),
    .full_i     (full),
    .push_o     (push),
    .beam_o     (push_beam)
  );

  lbcc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_beam),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_beam)
  );

  lbcc_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (q_valid),
    .beam_i  (pop_beam),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
